@@ hdl/interval_sort_merge_table_assert.svh @@
// assertion macros for the interval table
`ifndef INTERVAL_SORT_MERGE_TABLE_ASSERT_SVH
`define INTERVAL_SORT_MERGE_TABLE_ASSERT_SVH

// implication checked on every edge outside reset
`define ISMT_ASSERT_IMP(label, clk, rst_n, cond, prop, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);

// implication checked in the cycle after the condition
`define ISMT_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

`endif

@@ hdl/ismt_pkg.sv @@
package ismt_pkg;

    localparam int unsigned CAPACITY_DEF  = 256;
    localparam int unsigned POS_WIDTH_DEF = 32;
    localparam int unsigned FLD_W         = 32;
    localparam int unsigned FLAG_W        = 8;
    localparam int unsigned IDX_W         = 8;
    localparam int unsigned CNT_W         = 9;

    typedef enum logic [1:0] {
        CMD_APPEND = 2'd0,
        CMD_PRUNE  = 2'd1,
        CMD_GET    = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_HIGH_LOW  = 2'd1,
        ST_FULL      = 2'd2,
        ST_RANGE     = 2'd3
    } t_status;

    typedef struct packed {
        logic [1:0]        command;
        logic [FLD_W-1:0]  low_pos;
        logic [FLD_W-1:0]  high_pos;
        logic [FLD_W-1:0]  seq_index;
        logic [FLAG_W-1:0] flag_in;
        logic [IDX_W-1:0]  entry_index;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]        status;
        logic [FLD_W-1:0]  low_out;
        logic [FLD_W-1:0]  high_out;
        logic [FLD_W-1:0]  seq_out;
        logic [FLAG_W-1:0] flag_out;
        logic [CNT_W-1:0]  entry_count;
    } t_out_beat;

endpackage

@@ hdl/ismt_if.sv @@
interface ismt_in_if;
    logic                valid;
    logic                ready;
    ismt_pkg::t_in_beat  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ismt_out_if;
    logic                valid;
    logic                ready;
    ismt_pkg::t_out_beat data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/interval_sort_merge_table.sv @@
// Interval table with append (0), prune (1), get (2) and clear (3) commands, one result
// beat per command beat. Entries sit in a single-port synchronous memory (one read or
// write per cycle, registered read data), so commands run one at a time: the input
// is not ready from the accepting edge until the result beat has been taken. Append
// and clear answer straight from idle, get after a read of the memory. Prune runs an
// insertion sort and then a merge pass through that memory port; the sort makes at
// most n*(n-1)/2 entry moves, where n is the entry count. A prune of one entry or
// none answers straight from idle.
module interval_sort_merge_table #(
    parameter int unsigned CAPACITY  = ismt_pkg::CAPACITY_DEF,
    parameter int unsigned POS_WIDTH = ismt_pkg::POS_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    ismt_in_if.sink           i_in,
    ismt_out_if.source        o_out
);
`include "interval_sort_merge_table_assert.svh"

    localparam int unsigned AW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned NW  = $clog2(CAPACITY + 1);
    localparam int unsigned EW  = 3 * POS_WIDTH + ismt_pkg::FLAG_W;

    typedef struct packed {
        logic [POS_WIDTH-1:0]        seq;
        logic [POS_WIDTH-1:0]        lo;
        logic [POS_WIDTH-1:0]        hi;
        logic [ismt_pkg::FLAG_W-1:0] flag;
    } t_entry;

    typedef enum logic [3:0] {
        S_IDLE, S_GET_RD, S_GET_WAIT,
        S_SRT_RDJ, S_SRT_RDP, S_SRT_CMP, S_SRT_WR, S_SRT_NEXT,
        S_MRG_RDI, S_MRG_RDJ, S_MRG_STEP, S_MRG_WRI, S_DONE
    } t_state;

    t_entry mem [CAPACITY];
    logic [EW-1:0] r_rdata;

    t_state              r_state;
    logic [NW-1:0]       r_count;
    logic [NW-1:0]       r_j;
    logic [NW-1:0]       r_i;
    t_entry              r_key;
    t_entry              r_cur;
    t_entry              r_acc;
    logic                r_out_valid;
    ismt_pkg::t_out_beat r_out;
    ismt_pkg::t_out_beat n_out;

    logic          mem_we;
    logic          mem_re;
    logic [AW-1:0] mem_addr;
    t_entry        mem_wdata;
    t_entry        rd;

    assign rd = t_entry'(r_rdata);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= mem[mem_addr];
        end
    end

    function automatic logic after_key(t_entry a, t_entry b);
        if (a.seq != b.seq) return a.seq > b.seq;
        if (a.lo != b.lo) return a.lo > b.lo;
        return a.hi > b.hi;
    endfunction

    function automatic ismt_pkg::t_cmd t_cmd_f(logic [1:0] c);
        return ismt_pkg::t_cmd'(c);
    endfunction

    logic accept;
    assign accept      = i_in.valid && i_in.ready;
    assign i_in.ready  = (r_state == S_IDLE) && !r_out_valid;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    t_entry in_e;
    always_comb begin
        in_e.seq  = POS_WIDTH'(i_in.data.seq_index);
        in_e.lo   = POS_WIDTH'(i_in.data.low_pos);
        in_e.hi   = POS_WIDTH'(i_in.data.high_pos);
        in_e.flag = i_in.data.flag_in;
    end

    logic app_bad;
    logic app_full;
    logic get_oob;
    logic clear_acc;
    logic mrg_join;
    assign app_bad   = in_e.hi < in_e.lo;
    assign app_full  = r_count >= NW'(CAPACITY);
    assign get_oob   = (32'(i_in.data.entry_index) >= 32'(r_count))
                       || (32'(i_in.data.entry_index) >= 32'(CAPACITY));
    assign clear_acc = accept && (t_cmd_f(i_in.data.command) == ismt_pkg::CMD_CLEAR);
    assign mrg_join  = (r_cur.seq == r_acc.seq) && (r_cur.lo <= r_acc.hi);

    // result beat for a command taken in idle
    always_comb begin
        n_out             = '0;
        n_out.status      = ismt_pkg::ST_OK;
        n_out.entry_count = ismt_pkg::CNT_W'(r_count);
        unique case (t_cmd_f(i_in.data.command))
            ismt_pkg::CMD_APPEND: begin
                if (app_bad) begin
                    n_out.status = ismt_pkg::ST_HIGH_LOW;
                end else if (app_full) begin
                    n_out.status = ismt_pkg::ST_FULL;
                end else begin
                    n_out.entry_count = ismt_pkg::CNT_W'(r_count + 1'b1);
                end
            end
            ismt_pkg::CMD_GET: begin
                if (get_oob) begin
                    n_out.status = ismt_pkg::ST_RANGE;
                end
            end
            ismt_pkg::CMD_CLEAR: begin
                n_out.entry_count = '0;
            end
            default: ;
        endcase
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_addr  = '0;
        mem_wdata = r_key;
        unique case (r_state)
            S_IDLE: begin
                mem_addr  = r_count[AW-1:0];
                mem_wdata = in_e;
                mem_we    = accept && (t_cmd_f(i_in.data.command) == ismt_pkg::CMD_APPEND)
                            && !app_bad && !app_full;
            end
            S_GET_RD: begin
                mem_re   = 1'b1;
                mem_addr = r_j[AW-1:0];
            end
            S_SRT_RDJ: begin
                mem_re   = 1'b1;
                mem_addr = r_j[AW-1:0];
            end
            S_SRT_RDP: begin
                mem_re   = 1'b1;
                mem_addr = AW'(r_i - 1'b1);
            end
            S_SRT_CMP: begin
                mem_addr  = r_i[AW-1:0];
                mem_wdata = rd;
                mem_we    = after_key(rd, r_key);
            end
            S_SRT_WR: begin
                mem_addr  = r_i[AW-1:0];
                mem_wdata = r_key;
                mem_we    = 1'b1;
            end
            S_MRG_RDI: begin
                mem_re   = 1'b1;
                mem_addr = '0;
            end
            S_MRG_RDJ: begin
                mem_re   = 1'b1;
                mem_addr = r_j[AW-1:0];
            end
            S_MRG_WRI: begin
                mem_addr  = r_i[AW-1:0];
                mem_wdata = r_acc;
                mem_we    = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_out.valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_out <= n_out;
                        unique case (t_cmd_f(i_in.data.command))
                            ismt_pkg::CMD_APPEND: begin
                                r_out_valid <= 1'b1;
                                if (!app_bad && !app_full) begin
                                    r_count <= r_count + 1'b1;
                                end
                            end
                            ismt_pkg::CMD_PRUNE: begin
                                if (r_count <= NW'(1)) begin
                                    r_out_valid <= 1'b1;
                                end else begin
                                    r_j     <= NW'(1);
                                    r_state <= S_SRT_RDJ;
                                end
                            end
                            ismt_pkg::CMD_GET: begin
                                if (get_oob) begin
                                    r_out_valid <= 1'b1;
                                end else begin
                                    r_j     <= NW'(i_in.data.entry_index);
                                    r_state <= S_GET_RD;
                                end
                            end
                            ismt_pkg::CMD_CLEAR: begin
                                r_count     <= '0;
                                r_out_valid <= 1'b1;
                            end
                            default: ;
                        endcase
                    end
                end
                S_GET_RD:   r_state <= S_GET_WAIT;
                S_GET_WAIT: begin
                    r_out.low_out  <= ismt_pkg::FLD_W'(rd.lo);
                    r_out.high_out <= ismt_pkg::FLD_W'(rd.hi);
                    r_out.seq_out  <= ismt_pkg::FLD_W'(rd.seq);
                    r_out.flag_out <= rd.flag;
                    r_out_valid    <= 1'b1;
                    r_state        <= S_IDLE;
                end
                S_SRT_RDJ: begin
                    r_i     <= r_j;
                    r_state <= S_SRT_RDP;
                end
                S_SRT_RDP: begin
                    if (r_i == r_j) begin
                        r_key <= rd;
                    end
                    r_state <= S_SRT_CMP;
                end
                S_SRT_CMP: begin
                    if (after_key(rd, r_key)) begin
                        r_i     <= r_i - 1'b1;
                        r_state <= (r_i == NW'(1)) ? S_SRT_WR : S_SRT_RDP;
                    end else begin
                        r_state <= S_SRT_WR;
                    end
                end
                S_SRT_WR: r_state <= S_SRT_NEXT;
                S_SRT_NEXT: begin
                    if (r_j + 1'b1 >= r_count) begin
                        r_state <= S_MRG_RDI;
                    end else begin
                        r_j     <= r_j + 1'b1;
                        r_state <= S_SRT_RDJ;
                    end
                end
                S_MRG_RDI: begin
                    r_i     <= '0;
                    r_j     <= NW'(1);
                    r_state <= S_MRG_RDJ;
                end
                S_MRG_RDJ: begin
                    if (r_j == NW'(1)) begin
                        r_acc <= rd;
                    end
                    r_state <= S_MRG_STEP;
                end
                S_MRG_STEP: begin
                    if (rd.seq == r_acc.seq && rd.lo <= r_acc.hi && rd.hi > r_acc.hi) begin
                        r_acc.hi <= rd.hi;
                    end
                    r_cur   <= rd;
                    r_state <= S_MRG_WRI;
                end
                S_MRG_WRI: begin
                    if (r_j == r_count) begin
                        r_count           <= r_i + 1'b1;
                        r_out.entry_count <= ismt_pkg::CNT_W'(r_i + 1'b1);
                        r_out_valid       <= 1'b1;
                        r_state           <= S_IDLE;
                    end else begin
                        if (!mrg_join) begin
                            r_acc <= r_cur;
                            r_i   <= r_i + 1'b1;
                        end
                        r_j     <= r_j + 1'b1;
                        r_state <= (r_j + 1'b1 == r_count) ? S_MRG_WRI : S_DONE;
                    end
                end
                S_DONE: r_state <= S_MRG_RDJ;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `ISMT_ASSERT_IMP(a_count_cap, i_clk, i_rst_n, 1'b1, r_count <= NW'(CAPACITY), "count overflow")
    `ISMT_ASSERT_IMP(a_busy_rdy, i_clk, i_rst_n, r_state != S_IDLE, !i_in.ready, "ready while busy")
    `ISMT_ASSERT_NEXT(a_clear_zero, i_clk, i_rst_n, clear_acc, r_count == '0, "clear left entries")

endmodule

@@ tb/sv/interval_sort_merge_table_test.sv @@
`timescale 1ns / 1ps

module interval_sort_merge_table_test;

    localparam int unsigned CAP = ismt_pkg::CAPACITY_DEF;

    logic i_clk;
    logic i_rst_n;
    logic last_phase;

    ismt_in_if  in_ch ();
    ismt_out_if out_ch ();

    interval_sort_merge_table u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    // predictor copy of the table
    logic [ismt_pkg::FLD_W-1:0]  tbl_low  [CAP];
    logic [ismt_pkg::FLD_W-1:0]  tbl_high [CAP];
    logic [ismt_pkg::FLD_W-1:0]  tbl_seq  [CAP];
    logic [ismt_pkg::FLAG_W-1:0] tbl_flag [CAP];
    int unsigned                 tbl_count;

    ismt_pkg::t_out_beat pending_results [$];
    int                  error_count;
    int                  beats_sent;
    int                  results_seen;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #400ms;
        $display("timeout at %0t", $time);
        $display("Some tests failed");
        $finish;
    end

    function automatic bit entry_after(int unsigned a, int unsigned b);
        if (tbl_seq[a] != tbl_seq[b]) return tbl_seq[a] > tbl_seq[b];
        if (tbl_low[a] != tbl_low[b]) return tbl_low[a] > tbl_low[b];
        return tbl_high[a] > tbl_high[b];
    endfunction

    function automatic void sort_and_merge();
        int unsigned                 i;
        int unsigned                 j;
        logic [ismt_pkg::FLD_W-1:0]  t;
        logic [ismt_pkg::FLAG_W-1:0] f;
        if (tbl_count == 0) return;
        for (j = 1; j < tbl_count; j++) begin
            i = j;
            while (i > 0 && entry_after(i - 1, i)) begin
                t = tbl_low[i-1];  tbl_low[i-1]  = tbl_low[i];  tbl_low[i]  = t;
                t = tbl_high[i-1]; tbl_high[i-1] = tbl_high[i]; tbl_high[i] = t;
                t = tbl_seq[i-1];  tbl_seq[i-1]  = tbl_seq[i];  tbl_seq[i]  = t;
                f = tbl_flag[i-1]; tbl_flag[i-1] = tbl_flag[i]; tbl_flag[i] = f;
                i--;
            end
        end
        i = 0;
        for (j = 1; j < tbl_count; j++) begin
            if (tbl_seq[j] == tbl_seq[i] && tbl_low[j] <= tbl_high[i]) begin
                if (tbl_high[j] > tbl_high[i]) tbl_high[i] = tbl_high[j];
            end else begin
                i++;
                tbl_low[i]  = tbl_low[j];
                tbl_high[i] = tbl_high[j];
                tbl_seq[i]  = tbl_seq[j];
                tbl_flag[i] = tbl_flag[j];
            end
        end
        tbl_count = i + 1;
    endfunction

    function automatic ismt_pkg::t_out_beat table_result(ismt_pkg::t_in_beat b);
        ismt_pkg::t_out_beat r;
        r = '0;
        r.status = ismt_pkg::ST_OK;
        case (ismt_pkg::t_cmd'(b.command))
            ismt_pkg::CMD_APPEND: begin
                if (b.high_pos < b.low_pos) r.status = ismt_pkg::ST_HIGH_LOW;
                else if (tbl_count >= CAP) r.status = ismt_pkg::ST_FULL;
                else begin
                    tbl_low[tbl_count]  = b.low_pos;
                    tbl_high[tbl_count] = b.high_pos;
                    tbl_seq[tbl_count]  = b.seq_index;
                    tbl_flag[tbl_count] = b.flag_in;
                    tbl_count++;
                end
            end
            ismt_pkg::CMD_PRUNE: sort_and_merge();
            ismt_pkg::CMD_GET: begin
                if (b.entry_index >= tbl_count) r.status = ismt_pkg::ST_RANGE;
                else begin
                    r.low_out  = tbl_low[b.entry_index];
                    r.high_out = tbl_high[b.entry_index];
                    r.seq_out  = tbl_seq[b.entry_index];
                    r.flag_out = tbl_flag[b.entry_index];
                end
            end
            default: tbl_count = 0;
        endcase
        r.entry_count = ismt_pkg::CNT_W'(tbl_count);
        return r;
    endfunction

    task automatic send_beat(ismt_pkg::t_in_beat b);
        int gap;
        if (!last_phase && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 11);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= b;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        pending_results.push_back(table_result(b));
        beats_sent++;
    endtask

    task automatic go_idle();
        in_ch.valid <= 1'b0;
    endtask

    function automatic ismt_pkg::t_in_beat make_beat(ismt_pkg::t_cmd c, logic [31:0] lo,
                                                     logic [31:0] hi, logic [31:0] sq,
                                                     logic [7:0] fl, logic [7:0] idx);
        ismt_pkg::t_in_beat b;
        b.command     = c;
        b.low_pos     = lo;
        b.high_pos    = hi;
        b.seq_index   = sq;
        b.flag_in     = fl;
        b.entry_index = idx;
        return b;
    endfunction

    // receiver with random stall bursts
    initial begin
        int stall;
        ismt_pkg::t_out_beat got;
        ismt_pkg::t_out_beat want;
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!last_phase && $urandom_range(0, 4) == 0) begin
                stall = $urandom_range(1, 11);
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge i_clk);
            if (out_ch.valid && out_ch.ready) begin
                got = out_ch.data;
                results_seen++;
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result %p", $time, got);
                    error_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (got.status !== want.status || got.low_out !== want.low_out ||
                        got.high_out !== want.high_out || got.seq_out !== want.seq_out ||
                        got.flag_out !== want.flag_out ||
                        got.entry_count !== want.entry_count) begin
                        $display("%0t: mismatch expected %p actual %p", $time, want, got);
                        error_count++;
                    end
                end
            end
        end
    end

    task automatic test_directed();
        send_beat(make_beat(ismt_pkg::CMD_GET, 0, 0, 0, 0, 8'd0));
        send_beat(make_beat(ismt_pkg::CMD_PRUNE, 0, 0, 0, 0, 0));
        send_beat(make_beat(ismt_pkg::CMD_APPEND, 32'd10, 32'd5, 0, 0, 0));
        send_beat(make_beat(ismt_pkg::CMD_APPEND, '1, '1, '1, 8'hff, 8'hff));
        send_beat(make_beat(ismt_pkg::CMD_APPEND, 0, 0, 0, 8'h00, 0));
        send_beat(make_beat(ismt_pkg::CMD_APPEND, 0, '1, 32'd3, 8'h5a, 0));
        send_beat(make_beat(ismt_pkg::CMD_APPEND, 32'd20, 32'd30, 32'd1, 8'h01, 0));
        send_beat(make_beat(ismt_pkg::CMD_APPEND, 32'd30, 32'd40, 32'd1, 8'h02, 0));
        send_beat(make_beat(ismt_pkg::CMD_APPEND, 32'd20, 32'd30, 32'd1, 8'h03, 0));
        send_beat(make_beat(ismt_pkg::CMD_APPEND, 32'd41, 32'd50, 32'd1, 8'h04, 0));
        send_beat(make_beat(ismt_pkg::CMD_GET, 0, 0, 0, 0, 8'd6));
        send_beat(make_beat(ismt_pkg::CMD_GET, 0, 0, 0, 0, 8'd7));
        send_beat(make_beat(ismt_pkg::CMD_PRUNE, 0, 0, 0, 0, 0));
        for (int k = 0; k < 6; k++)
            send_beat(make_beat(ismt_pkg::CMD_GET, 0, 0, 0, 0, 8'(k)));
        send_beat(make_beat(ismt_pkg::CMD_CLEAR, 0, 0, 0, 0, 0));
        send_beat(make_beat(ismt_pkg::CMD_GET, 0, 0, 0, 0, 8'd0));
    endtask

    // fill to capacity, refuse a full and a high-below-low append, read the last slot, then prune, read and clear
    task automatic test_full_table();
        for (int k = 0; k < CAP; k++)
            send_beat(make_beat(ismt_pkg::CMD_APPEND, 32'(k), 32'(k), 32'(CAP - k),
                                8'(k), 0));
        send_beat(make_beat(ismt_pkg::CMD_APPEND, 0, 1, 0, 0, 0));
        send_beat(make_beat(ismt_pkg::CMD_APPEND, 1, 0, 0, 0, 0));
        send_beat(make_beat(ismt_pkg::CMD_GET, 0, 0, 0, 0, 8'hff));
        send_beat(make_beat(ismt_pkg::CMD_PRUNE, 0, 0, 0, 0, 0));
        send_beat(make_beat(ismt_pkg::CMD_GET, 0, 0, 0, 0, 8'h00));
        send_beat(make_beat(ismt_pkg::CMD_CLEAR, 0, 0, 0, 0, 0));
    endtask

    // short append runs with clustered fields, then a prune in most rounds, reads and an occasional clear
    task automatic test_random_sets(int rounds);
        int                 n;
        logic [31:0]        lo;
        logic [31:0]        hi;
        logic [31:0]        base;
        ismt_pkg::t_in_beat b;
        for (int r = 0; r < rounds; r++) begin
            n = $urandom_range(1, 12);
            base = ($urandom_range(0, 3) == 0) ? $urandom() : 32'd0;
            for (int k = 0; k < n; k++) begin
                lo = base + $urandom_range(0, 40);
                hi = lo + $urandom_range(0, 15);
                if ($urandom_range(0, 9) == 0) begin
                    lo = $urandom();
                    hi = $urandom();
                end
                send_beat(make_beat(ismt_pkg::CMD_APPEND, lo, hi,
                    ($urandom_range(0, 4) == 0) ? $urandom() : 32'($urandom_range(0, 2)),
                    8'($urandom()), 0));
            end
            if ($urandom_range(0, 5) != 0)
                send_beat(make_beat(ismt_pkg::CMD_PRUNE, 0, 0, 0, 0, 0));
            repeat ($urandom_range(1, 5)) begin
                b = make_beat(ismt_pkg::CMD_GET, $urandom(), $urandom(), $urandom(),
                              8'($urandom()), 8'($urandom_range(0, tbl_count + 2)));
                if ($urandom_range(0, 7) == 0) b.entry_index = 8'($urandom());
                send_beat(b);
            end
            if ($urandom_range(0, 3) == 0)
                send_beat(make_beat(ismt_pkg::CMD_CLEAR, $urandom(), $urandom(),
                                    $urandom(), 8'($urandom()), 8'($urandom())));
        end
    endtask

    initial begin
        int wait_cycles;
        error_count  = 0;
        beats_sent   = 0;
        results_seen = 0;
        last_phase   = 1'b0;
        tbl_count    = 0;
        i_rst_n      <= 1'b0;
        in_ch.valid  <= 1'b0;
        in_ch.data   <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_full_table();
        test_random_sets(8);
        last_phase = 1'b1;
        test_random_sets(3);
        go_idle();
        wait_cycles = 0;
        while (pending_results.size() != 0 && wait_cycles < 2000000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (20) @(posedge i_clk);
        $display("sent %0d command beats, checked %0d result beats", beats_sent,
                 results_seen);
        $display("covered append refusals, full table, prune merges, reads and clears");
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
